[design/ptt_pkg.sv]
// Shared constants, tables and the arithmetic unit request type for the thrust/torque block.
`timescale 1ns / 1ps
`default_nettype none
package ptt_pkg;

    localparam int FRAC_BITS = 16;

    localparam logic [63:0] ONE_Q        = 64'd1 << FRAC_BITS;
    localparam logic [63:0] C_INV_PEAK   = 64'd12965559532;
    localparam logic [63:0] C_EB_INV     = 64'd2703263755;
    localparam logic [63:0] C_TAU        = 64'd2040139359;
    localparam logic [63:0] C_9999       = 64'd4294537800;
    localparam logic [63:0] C_MILLI      = 64'd4294967;
    localparam logic [63:0] LAM_NEAR_ONE = C_9999 >> (32 - FRAC_BITS);
    localparam logic [63:0] EPS_RAW      =
        (C_MILLI + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
    localparam logic [63:0] SHAFT_FLOOR  = (EPS_RAW == 64'd0) ? 64'd1 : EPS_RAW;
    localparam logic [63:0] JR_CAP       = (64'd1 << (63 - FRAC_BITS)) - 64'd1;
    localparam logic [63:0] LAM_CAP      = (64'd1 << 48) - 64'd1;
    localparam logic [63:0] T2_MAX       = 64'hFFFF_FFFF_FFFF_FFFF >> FRAC_BITS;
    localparam logic [63:0] POS48        = (64'd1 << 47) - 64'd1;
    localparam logic [63:0] NEG48        = 64'd1 << 47;

    // air_density is Q2.16 on the port, aligned to FRAC_BITS inside
    localparam int RHO_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int RHO_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    // 2^(2^-k) for k = 1..14, Q.30
    localparam int EXP_STEPS = 14;
    localparam logic [30:0] EXP_TAB [EXP_STEPS] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653034,
        31'd1075196443, 31'd1074468887, 31'd1074105294, 31'd1073923544,
        31'd1073832680, 31'd1073787251
    };

    // one operation for the shared bit-serial unit
    typedef struct packed {
        logic        is_div;  // 1: a / b, 0: (a * b + rounding) >> shamt
        logic        rnd;     // add half an LSB of the shifted result
        logic [5:0]  shamt;
        logic [63:0] a;
        logic [63:0] b;
    } ptt_alu_req_t;

endpackage
`default_nettype wire

[design/ptt_alu.sv]
// Bit-serial multiply-shift and restoring divide unit, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module ptt_alu import ptt_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire ptt_alu_req_t req,
    output logic              busy,
    output logic              done,
    output logic [63:0]       result
);

    typedef enum logic [4:0] {
        A_IDLE = 5'b00001,
        A_MUL  = 5'b00010,
        A_SHR  = 5'b00100,
        A_FIN  = 5'b01000,
        A_DIV  = 5'b10000
    } alu_state_t;

    alu_state_t   state_reg;
    logic [127:0] acc_reg;
    logic [63:0]  a_reg;
    logic [63:0]  b_reg;
    logic [5:0]   cnt_reg;
    logic [5:0]   shift_reg;
    logic         rnd_reg;
    logic         done_reg;
    logic [63:0]  result_reg;

    logic [64:0]  mul_sum;
    logic [64:0]  div_rem;
    logic [64:0]  div_diff;
    logic         div_ge;
    logic [128:0] rnd_sum;
    logic [127:0] fin_val;

    assign mul_sum  = {1'b0, acc_reg[127:64]} + (b_reg[0] ? {1'b0, a_reg} : 65'd0);
    assign div_rem  = {acc_reg[127:64], acc_reg[63]};
    assign div_ge   = div_rem >= {1'b0, b_reg};
    assign div_diff = div_rem - {1'b0, b_reg};
    assign rnd_sum  = {1'b0, acc_reg} + 129'd1;
    assign fin_val  = rnd_reg ? rnd_sum[128:1] : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        a_reg     <= req.a;
                        b_reg     <= req.b;
                        cnt_reg   <= 6'd0;
                        rnd_reg   <= req.rnd;
                        // rounding: shift one less, then (x + 1) >> 1
                        shift_reg <= req.shamt - {5'd0, req.rnd};
                        if (req.is_div) begin
                            acc_reg   <= {64'd0, req.a};
                            state_reg <= A_DIV;
                        end else begin
                            acc_reg   <= 128'd0;
                            state_reg <= A_MUL;
                        end
                    end
                end
                A_MUL: begin
                    acc_reg <= {mul_sum, acc_reg[63:1]};
                    b_reg   <= b_reg >> 1;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        state_reg <= A_SHR;
                    end
                end
                A_SHR: begin
                    if (shift_reg == 6'd0) begin
                        state_reg <= A_FIN;
                    end else begin
                        acc_reg   <= acc_reg >> 1;
                        shift_reg <= shift_reg - 6'd1;
                    end
                end
                A_FIN: begin
                    result_reg <= (|fin_val[127:64]) ? 64'hFFFF_FFFF_FFFF_FFFF
                                                     : fin_val[63:0];
                    done_reg   <= 1'b1;
                    state_reg  <= A_IDLE;
                end
                A_DIV: begin
                    acc_reg <= {div_ge ? div_diff[63:0] : div_rem[63:0],
                                acc_reg[62:0], div_ge};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63) begin
                        result_reg <= {acc_reg[62:0], div_ge};
                        done_reg   <= 1'b1;
                        state_reg  <= A_IDLE;
                    end
                end
                default: state_reg <= A_IDLE;
            endcase
        end
    end

    assign busy   = state_reg != A_IDLE;
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !busy && !req.is_div) |=> (state_reg == A_MUL))
        else $error("multiply did not start");
    a_done_one: assert property (@(posedge aclk) disable iff (!aresetn)
        done |=> !done)
        else $error("done held more than one cycle");
    a_div_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !busy && req.is_div) |=> (state_reg == A_DIV && cnt_reg == 6'd0))
        else $error("divide did not start cleanly");
`endif

endmodule
`default_nettype wire

[design/propeller_thrust_torque.sv]
// Propeller thrust and torque evaluator, top level with the operation sequencer.
`timescale 1ns / 1ps
`default_nettype none
// Every arithmetic step goes through one shared bit-serial unit (ptt_alu), so that unit
// sets the rate: a multiply also shifts its result one bit at a time (its shift s is 16..32,
// one less when rounded), and each step has a sequencer handoff. A compute beat (tuser = 0)
// runs 14 steps, or 12 steps when lambda is above one; with manual pitch mode on, up to 15
// more multiplies come first, and an exponent bit that is clear skips its multiply. A pitch
// beat (tuser = 1) gives no result. A new beat is taken when the previous one is finished,
// even while its result still waits on the master side.
// Config writes are always ready and belong in idle periods.
module propeller_thrust_torque import ptt_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // air_density[17:0], airspeed[49:18], shaft_speed[81:50], pitch_command[98:82],
    // feather[99], pitch_factor[131:100], zero pad[135:132]
    input  wire logic [135:0] s_tdata,
    // action[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // thrust[47:0], torque[95:48]
    output logic [95:0]       m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [3:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    localparam logic [3:0] REG_RADIUS    = 4'd0;
    localparam logic [3:0] REG_BASE      = 4'd1;
    localparam logic [3:0] REG_SCALE     = 4'd2;
    localparam logic [3:0] REG_TO_LIMIT  = 4'd3;
    localparam logic [3:0] REG_TO_ON     = 4'd4;
    localparam logic [3:0] REG_MANUAL    = 4'd5;
    localparam logic [3:0] REG_FINE      = 4'd6;
    localparam logic [3:0] REG_COARSE    = 4'd7;

    typedef enum logic [23:0] {
        ST_IDLE  = 24'h000001,
        ST_PJ    = 24'h000002,
        ST_PLO   = 24'h000004,
        ST_PHI   = 24'h000008,
        ST_MLOOP = 24'h000010,
        ST_MFIN  = 24'h000020,
        ST_TIP   = 24'h000040,
        ST_VSQ   = 24'h000080,
        ST_TSQ   = 24'h000100,
        ST_RHOV  = 24'h000200,
        ST_Q     = 24'h000400,
        ST_JR    = 24'h000800,
        ST_LAM   = 24'h001000,
        ST_TCM   = 24'h002000,
        ST_THR   = 24'h004000,
        ST_L2    = 24'h008000,
        ST_L4    = 24'h010000,
        ST_TJ    = 24'h020000,
        ST_T2    = 24'h040000,
        ST_TDIV  = 24'h080000,
        ST_TAU   = 24'h100000,
        ST_TY    = 24'h200000,
        ST_TQ    = 24'h400000,
        ST_OUT   = 24'h800000
    } seq_state_t;

    function automatic logic [31:0] sat32(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] x, input logic [63:0] y);
        logic [64:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [47:0] pack48(input logic [63:0] mag, input logic neg);
        logic [63:0] m;
        logic [63:0] n;
        m = (mag > NEG48) ? NEG48 : mag;
        n = 64'd0 - m;
        return neg ? n[47:0] : ((mag > POS48) ? POS48[47:0] : mag[47:0]);
    endfunction

    // configuration
    logic [31:0] radius_reg, base_reg, scale_reg, to_limit_reg, fine_reg, coarse_reg;
    logic        to_on_reg, manual_reg;
    logic [31:0] cur_j0_reg;

    // latched beat
    logic [17:0] rho_reg;
    logic [31:0] vel_reg, rot_reg, factor_reg;
    logic [16:0] pcmd_reg;
    logic        feather_reg;

    // working registers
    seq_state_t  state_reg, state_next;
    logic        issued_reg;
    logic [3:0]  k_reg;
    logic [63:0] m_reg;
    logic [63:0] t0_reg, t1_reg, q_reg, thr_reg, trq_reg;
    logic [47:0] lam_reg;
    logic        qneg_reg;
    logic        m_tvalid_reg;
    logic [95:0] m_tdata_reg;

    // arithmetic unit
    ptt_alu_req_t alu_req;
    logic         alu_start, alu_busy, alu_done;
    logic [63:0]  alu_res;

    logic        s_accept, out_free, needs_alu, skip, step;
    logic [31:0] av, aw, vpos;
    logic        rot_small;
    logic [63:0] wpos, rho_ext, lam64, lam_d, lam_q, lam_fix, tcm_fix;
    logic [16:0] p_sat;
    logic [18:0] exp_e;
    logic [2:0]  ip;
    logic        fr_bit;
    logic        tneg;
    logic [50:0] five, six, absdiff;
    logic        qneg_c;
    logic [31:0] pj1, pj2, hi_stop;
    logic [63:0] thr_f;

    assign s_tready  = state_reg == ST_IDLE;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign av        = vel_reg[31] ? (~vel_reg + 32'd1) : vel_reg;
    assign aw        = rot_reg[31] ? (~rot_reg + 32'd1) : rot_reg;
    assign vpos      = vel_reg[31] ? 32'd0 : vel_reg;
    assign rot_small = rot_reg[31] || ({32'd0, rot_reg} < SHAFT_FLOOR);
    assign wpos      = rot_small ? SHAFT_FLOOR : {32'd0, rot_reg};
    assign rho_ext   = ({46'd0, rho_reg} << RHO_UP) >> RHO_DN;

    // manual pitch: J0 = base * 2^(2 - 4p), exponent split into integer and fraction
    assign p_sat  = (pcmd_reg > 17'd65536) ? 17'd65536 : pcmd_reg;
    assign exp_e  = 19'd262144 - {p_sat, 2'b00};
    assign ip     = exp_e[18:16];
    assign fr_bit = exp_e[4'd15 - k_reg];

    assign lam64   = {16'd0, lam_reg};
    assign tneg    = lam64 > ONE_Q;
    assign lam_d   = tneg ? (lam64 - ONE_Q) : (ONE_Q - lam64);
    assign five    = {1'b0, lam_reg, 2'b00} + {3'd0, lam_reg};
    assign six     = 51'(ONE_Q * 64'd6);
    assign qneg_c  = five > six;
    assign absdiff = qneg_c ? (five - six) : (six - five);

    assign lam_q   = (alu_res > LAM_CAP) ? LAM_CAP : alu_res;
    assign lam_fix = (lam_q == ONE_Q) ? LAM_NEAR_ONE : lam_q;
    assign tcm_fix = (!tneg && to_on_reg && alu_res > {32'd0, to_limit_reg})
                     ? {32'd0, to_limit_reg} : alu_res;

    assign pj1     = (t0_reg[31:0] < t1_reg[31:0]) ? t1_reg[31:0] : t0_reg[31:0];
    assign hi_stop = sat32(alu_res);
    assign pj2     = (pj1 > hi_stop) ? hi_stop : pj1;   // coarse stop wins
    assign thr_f   = feather_reg ? 64'd0 : thr_reg;

    always_comb begin
        alu_req   = '{is_div: 1'b0, rnd: 1'b0, shamt: 6'(FRAC_BITS), a: 64'd0, b: 64'd0};
        needs_alu = 1'b1;
        skip      = 1'b0;
        unique case (state_reg)
            ST_PJ:    begin alu_req.a = {32'd0, cur_j0_reg}; alu_req.b = {32'd0, factor_reg}; end
            ST_PLO:   begin alu_req.a = {32'd0, fine_reg};   alu_req.b = {32'd0, base_reg}; end
            ST_PHI:   begin alu_req.a = {32'd0, coarse_reg}; alu_req.b = {32'd0, base_reg}; end
            ST_MLOOP: begin
                alu_req.a     = m_reg;
                alu_req.b     = {33'd0, EXP_TAB[k_reg]};
                alu_req.shamt = 6'd30;
                alu_req.rnd   = 1'b1;
                skip          = !fr_bit;
            end
            ST_MFIN:  begin
                alu_req.a     = {32'd0, base_reg};
                alu_req.b     = m_reg;
                alu_req.shamt = 6'd32 - {3'd0, ip};
                alu_req.rnd   = 1'b1;
            end
            ST_TIP:   begin alu_req.a = {32'd0, radius_reg}; alu_req.b = {32'd0, aw}; end
            ST_VSQ:   begin alu_req.a = {32'd0, av}; alu_req.b = {32'd0, av}; end
            ST_TSQ:   begin alu_req.a = t0_reg; alu_req.b = t0_reg; end
            ST_RHOV:  begin
                alu_req.a = rho_ext; alu_req.b = t1_reg; alu_req.shamt = 6'(FRAC_BITS + 1);
            end
            ST_Q:     begin alu_req.a = t1_reg; alu_req.b = {32'd0, scale_reg}; end
            ST_JR:    begin
                alu_req.is_div = 1'b1;
                alu_req.a      = {32'd0, vpos} << FRAC_BITS;
                alu_req.b      = wpos;
            end
            ST_LAM:   begin
                alu_req.is_div = 1'b1;
                alu_req.a      = t0_reg << FRAC_BITS;
                alu_req.b      = {32'd0, cur_j0_reg};
                skip           = cur_j0_reg == 32'd0;
            end
            ST_TCM:   begin alu_req.a = lam_d; alu_req.b = C_INV_PEAK; alu_req.shamt = 6'd32; end
            ST_THR:   begin alu_req.a = q_reg; alu_req.b = t0_reg; end
            ST_L2:    begin alu_req.a = lam64; alu_req.b = lam64; end
            ST_L4:    begin alu_req.a = t0_reg; alu_req.b = t0_reg; end
            ST_TJ:    begin alu_req.a = thr_reg; alu_req.b = {32'd0, cur_j0_reg}; end
            ST_T2:    begin alu_req.a = t0_reg; alu_req.b = C_EB_INV; alu_req.shamt = 6'd32; end
            ST_TDIV:  begin
                alu_req.is_div = 1'b1;
                alu_req.a      = t0_reg << FRAC_BITS;
                alu_req.b      = t1_reg;
                skip           = (t1_reg == 64'd0) || (t0_reg > T2_MAX);
            end
            ST_TAU:   begin
                alu_req.a = {32'd0, cur_j0_reg}; alu_req.b = C_TAU; alu_req.shamt = 6'd32;
            end
            ST_TY:    begin alu_req.a = t0_reg; alu_req.b = {13'd0, absdiff}; end
            ST_TQ:    begin alu_req.a = t0_reg; alu_req.b = q_reg; end
            ST_IDLE, ST_OUT: needs_alu = 1'b0;
            default:  needs_alu = 1'b0;
        endcase
    end

    assign alu_start = needs_alu && !issued_reg && !skip;
    assign step      = alu_done || (needs_alu && !issued_reg && skip);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_accept) begin
                if (s_tuser)         state_next = ST_PJ;
                else if (manual_reg) state_next = ST_MLOOP;
                else                 state_next = ST_TIP;
            end
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            ST_PJ:    if (step) state_next = ST_PLO;
            ST_PLO:   if (step) state_next = ST_PHI;
            ST_PHI:   if (step) state_next = ST_IDLE;
            ST_MLOOP: if (step && k_reg == 4'(EXP_STEPS - 1)) state_next = ST_MFIN;
            ST_MFIN:  if (step) state_next = ST_TIP;
            ST_TIP:   if (step) state_next = ST_VSQ;
            ST_VSQ:   if (step) state_next = ST_TSQ;
            ST_TSQ:   if (step) state_next = ST_RHOV;
            ST_RHOV:  if (step) state_next = ST_Q;
            ST_Q:     if (step) state_next = ST_JR;
            ST_JR:    if (step) state_next = ST_LAM;
            ST_LAM:   if (step) state_next = ST_TCM;
            ST_TCM:   if (step) state_next = ST_THR;
            ST_THR:   if (step) state_next = tneg ? ST_TAU : ST_L2;
            ST_L2:    if (step) state_next = ST_L4;
            ST_L4:    if (step) state_next = ST_TJ;
            ST_TJ:    if (step) state_next = ST_T2;
            ST_T2:    if (step) state_next = ST_TDIV;
            ST_TDIV:  if (step) state_next = ST_OUT;
            ST_TAU:   if (step) state_next = ST_TY;
            ST_TY:    if (step) state_next = ST_TQ;
            ST_TQ:    if (step) state_next = ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issued_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
            radius_reg   <= 32'd65536;
            base_reg     <= 32'd65536;
            scale_reg    <= 32'd65536;
            to_limit_reg <= 32'd65536;
            to_on_reg    <= 1'b0;
            manual_reg   <= 1'b0;
            fine_reg     <= 32'd0;
            coarse_reg   <= 32'hFFFF_FFFF;
            cur_j0_reg   <= 32'd65536;
        end else begin
            state_reg <= state_next;
            if (alu_start) begin
                issued_reg <= 1'b1;
            end else if (alu_done) begin
                issued_reg <= 1'b0;
            end

            if (s_accept) begin
                rho_reg     <= s_tdata[17:0];
                vel_reg     <= s_tdata[49:18];
                rot_reg     <= s_tdata[81:50];
                pcmd_reg    <= s_tdata[98:82];
                feather_reg <= s_tdata[99];
                factor_reg  <= s_tdata[131:100];
                m_reg       <= 64'd1 << 30;
                k_reg       <= 4'd0;
            end

            if (step) begin
                case (state_reg)
                    ST_PJ:    t0_reg <= {32'd0, sat32(alu_res)};
                    ST_PLO:   t1_reg <= {32'd0, sat32(alu_res)};
                    ST_PHI:   cur_j0_reg <= pj2;
                    ST_MLOOP: begin
                        if (alu_done) begin
                            m_reg <= alu_res;
                        end
                        k_reg <= k_reg + 4'd1;
                    end
                    ST_MFIN:  cur_j0_reg <= sat32(alu_res);
                    ST_TIP:   t0_reg <= alu_res;
                    ST_VSQ:   t1_reg <= alu_res;
                    ST_TSQ:   t1_reg <= sat_add(t1_reg, alu_res);
                    ST_RHOV:  t1_reg <= alu_res;
                    ST_Q:     q_reg <= alu_res;
                    ST_JR:    t0_reg <= (alu_res > JR_CAP) ? JR_CAP : alu_res;
                    ST_LAM:   lam_reg <= (cur_j0_reg == 32'd0) ? LAM_CAP[47:0] : lam_fix[47:0];
                    ST_TCM:   t0_reg <= tcm_fix;
                    ST_THR:   thr_reg <= alu_res;
                    ST_L2:    t0_reg <= alu_res;
                    ST_L4:    t1_reg <= (alu_res < ONE_Q) ? (ONE_Q - alu_res) : 64'd0;
                    ST_TJ:    t0_reg <= alu_res;
                    ST_T2:    t0_reg <= alu_res;
                    ST_TDIV:  begin
                        trq_reg  <= alu_done ? alu_res : 64'hFFFF_FFFF_FFFF_FFFF;
                        qneg_reg <= 1'b0;
                    end
                    ST_TAU:   t0_reg <= alu_res;
                    ST_TY:    begin
                        t0_reg   <= alu_res;
                        qneg_reg <= qneg_c;
                    end
                    ST_TQ:    trq_reg <= alu_res;
                    default:  ;
                endcase
            end

            if (state_reg == ST_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {pack48(trq_reg, qneg_reg && trq_reg != 64'd0),
                                 pack48(thr_f, tneg && thr_f != 64'd0)};
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_RADIUS:   radius_reg <= cfg_data;
                    REG_BASE:     begin
                        base_reg   <= cfg_data;
                        cur_j0_reg <= cfg_data;
                    end
                    REG_SCALE:    scale_reg    <= cfg_data;
                    REG_TO_LIMIT: to_limit_reg <= cfg_data;
                    REG_TO_ON:    to_on_reg    <= cfg_data[0];
                    REG_MANUAL:   manual_reg   <= cfg_data[0];
                    REG_FINE:     fine_reg     <= cfg_data;
                    REG_COARSE:   coarse_reg   <= cfg_data;
                    default:      ;
                endcase
            end
        end
    end

    ptt_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (alu_start),
        .req     (alu_req),
        .busy    (alu_busy),
        .done    (alu_done),
        .result  (alu_res)
    );

`ifndef SYNTHESIS
    a_start_free: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_start |-> !alu_busy)
        else $error("operation issued while unit busy");
    a_done_owned: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> issued_reg)
        else $error("unit result with no operation outstanding");
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free) |=> (m_tvalid && state_reg == ST_IDLE))
        else $error("result beat not loaded");
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken without starting work");
`endif

endmodule
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the propeller thrust and torque block.
`timescale 1ns / 1ps
module tb_top;
    import ptt_pkg::*;

    localparam int  N_RANDOM  = 630;
    localparam longint LIMIT  = 12_000_000;
    localparam int  SETTLE    = 700;

    typedef enum int { IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH } idle_mode_t;
    typedef enum logic { ACT_COMPUTE = 1'b0, ACT_PITCH = 1'b1 } action_t;
    typedef enum logic [3:0] {
        REG_RADIUS = 4'd0, REG_BASE_J0 = 4'd1, REG_F0 = 4'd2, REG_TC_LIMIT = 4'd3,
        REG_LIMIT_ON = 4'd4, REG_MANUAL = 4'd5, REG_FINE = 4'd6, REG_COARSE = 4'd7
    } reg_index_t;

    typedef struct {
        action_t     act;
        logic [17:0] rho;
        logic [31:0] vel;
        logic [31:0] rot;
        logic [16:0] pcmd;
        logic        feather;
        logic [31:0] factor;
    } prop_beat_t;

    typedef struct {
        logic [47:0] thrust;
        logic [47:0] torque;
    } prop_out_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [3:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;

    propeller_thrust_torque u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // predictor copy of the registers and J0
    logic [63:0] radius_q, base_j0, f0_scale, tc_limit, fine_q, coarse_q, j0_now;
    logic        limit_on, manual_on;

    prop_out_t   expected_q[$];
    int          errors = 0;
    int          n_beats = 0, n_pitch = 0, n_results = 0;
    longint      cycles = 0;
    idle_mode_t  idle_mode = IDLE_NONE;

    function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                            input int s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
    endfunction

    function automatic logic [63:0] clip32(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : x;
    endfunction

    function automatic logic [47:0] to_q48(input logic [63:0] mag, input logic neg);
        logic [63:0] r;
        if (neg) r = 64'd0 - ((mag > NEG48) ? NEG48 : mag);
        else     r = (mag > POS48) ? POS48 : mag;
        return r[47:0];
    endfunction

    // base * 2^(2 - 4p), p already limited to one
    function automatic logic [63:0] pitch_to_j0(input logic [63:0] p);
        logic [63:0] e, fr, m;
        int ip;
        e  = 64'd262144 - 4 * p;
        ip = int'(e >> 16);
        fr = e & 64'hFFFF;
        m  = 64'd1 << 30;
        for (int k = 1; k <= EXP_STEPS; k++)
            if (fr[16 - k]) m = (m * {33'd0, EXP_TAB[k - 1]} + (64'd1 << 29)) >> 30;
        return clip32((base_j0 * m + (64'd1 << (31 - ip))) >> (32 - ip));
    endfunction

    function automatic bit prop_eval(input prop_beat_t b, output prop_out_t r);
        logic [63:0] rho, av, aw, tip, vsq, dyn_q, vpos, wpos, jr, lam, j0;
        logic [63:0] tc, thr, trq, lo_stop, hi_stop, l2, l4, den, t2, tau, five, six;
        longint vel, rot;
        logic tneg, qneg;
        r = '{default: '0};
        if (b.act == ACT_PITCH) begin
            j0 = clip32(mul_shr(j0_now, {32'd0, b.factor}, FRAC_BITS));
            lo_stop = clip32(mul_shr(fine_q, base_j0, FRAC_BITS));
            hi_stop = clip32(mul_shr(coarse_q, base_j0, FRAC_BITS));
            if (j0 < lo_stop) j0 = lo_stop;
            if (j0 > hi_stop) j0 = hi_stop;
            j0_now = j0;
            return 1'b0;
        end
        if (manual_on)
            j0_now = pitch_to_j0((b.pcmd > 17'd65536) ? 64'd65536 : {47'd0, b.pcmd});
        j0 = j0_now;
        rho = ({46'd0, b.rho} << RHO_UP) >> RHO_DN;
        vel = longint'(signed'(b.vel));
        rot = longint'(signed'(b.rot));
        av = (vel < 0) ? -vel : vel;
        aw = (rot < 0) ? -rot : rot;
        tip = mul_shr(radius_q, aw, FRAC_BITS);
        vsq = add_sat(mul_shr(av, av, FRAC_BITS), mul_shr(tip, tip, FRAC_BITS));
        dyn_q = mul_shr(mul_shr(rho, vsq, FRAC_BITS + 1), f0_scale, FRAC_BITS);
        vpos = (vel < 0) ? 64'd0 : vel;
        wpos = (rot < longint'(SHAFT_FLOOR)) ? SHAFT_FLOOR : rot;
        jr = (vpos << FRAC_BITS) / wpos;
        if (jr > JR_CAP) jr = JR_CAP;
        lam = (j0 == 0) ? LAM_CAP : (jr << FRAC_BITS) / j0;
        if (lam > LAM_CAP) lam = LAM_CAP;
        if (lam == ONE_Q) lam = LAM_NEAR_ONE;
        tneg = lam > ONE_Q;
        tc = mul_shr(tneg ? lam - ONE_Q : ONE_Q - lam, C_INV_PEAK, 32);
        if (!tneg && limit_on && tc > tc_limit) tc = tc_limit;
        thr = mul_shr(dyn_q, tc, FRAC_BITS);
        if (!tneg) begin
            l2 = mul_shr(lam, lam, FRAC_BITS);
            l4 = mul_shr(l2, l2, FRAC_BITS);
            den = (l4 < ONE_Q) ? ONE_Q - l4 : 64'd0;
            t2 = mul_shr(mul_shr(thr, j0, FRAC_BITS), C_EB_INV, 32);
            trq = (den == 0 || t2 > T2_MAX) ? 64'hFFFF_FFFF_FFFF_FFFF
                                            : (t2 << FRAC_BITS) / den;
            qneg = 1'b0;
        end else begin
            // windmilling: linear extrapolation past lambda one
            tau = mul_shr(j0, C_TAU, 32);
            five = 5 * lam;
            six = 6 * ONE_Q;
            qneg = five > six;
            trq = mul_shr(mul_shr(tau, qneg ? five - six : six - five, FRAC_BITS),
                          dyn_q, FRAC_BITS);
        end
        if (b.feather) thr = '0;
        r.thrust = to_q48(thr, tneg && thr != 0);
        r.torque = to_q48(trq, qneg && trq != 0);
        return 1'b1;
    endfunction

    task automatic reg_write(input reg_index_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_RADIUS:   radius_q = {32'd0, val};
            REG_BASE_J0:  begin base_j0 = {32'd0, val}; j0_now = {32'd0, val}; end
            REG_F0:       f0_scale = {32'd0, val};
            REG_TC_LIMIT: tc_limit = {32'd0, val};
            REG_LIMIT_ON: limit_on = val[0];
            REG_MANUAL:   manual_on = val[0];
            REG_FINE:     fine_q = {32'd0, val};
            REG_COARSE:   coarse_q = {32'd0, val};
            default: ;
        endcase
    endtask

    task automatic write_settings(input logic [31:0] v[8]);
        for (int i = 0; i < 8; i++) reg_write(reg_index_t'(i), v[i]);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // hold the input side until every outstanding result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // drive one beat and queue its predicted result, if it has one
    task automatic send_beat(input prop_beat_t b);
        prop_out_t r;
        if (idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) begin
            while ($urandom_range(99) < ((idle_mode == IDLE_SRC) ? 88 : 27)) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= b.act;
        s_tdata  <= {4'd0, b.factor, b.feather, b.pcmd, b.rot, b.vel, b.rho};
        do @(posedge aclk); while (!s_tready);
        n_beats++;
        if (prop_eval(b, r)) expected_q.push_back(r);
        else n_pitch++;
    endtask

    function automatic prop_beat_t rand_beat();
        prop_beat_t b;
        longint k;
        b.act = ($urandom_range(4) == 0) ? ACT_PITCH : ACT_COMPUTE;
        b.rho = ($urandom_range(7) == 0) ? 18'($urandom) : 18'($urandom_range(0, 'h14000));
        b.pcmd = ($urandom_range(7) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        b.feather = ($urandom_range(5) == 0);
        b.factor = ($urandom_range(7) == 0) ? $urandom : $urandom_range('h8000, 'h20000);
        case ($urandom_range(7))
            0: b.rot = $urandom;
            1: b.rot = $urandom_range(0, 200);
            default: b.rot = $urandom_range(32'h1_0000, 32'd400 << 16);
        endcase
        case ($urandom_range(9))
            0: b.vel = $urandom;
            1: b.vel = -$urandom_range(0, 32'd100 << 16);
            2: b.vel = b.rot;
            default: begin
                k = longint'(b.rot) * $urandom_range(0, 160) / 64;
                b.vel = k[31:0];
            end
        endcase
        return b;
    endfunction

    task automatic run_random(input idle_mode_t mode, input int n, input bit pause_mid);
        idle_mode = mode;
        for (int i = 0; i < n; i++) begin
            if (pause_mid && i == n / 2) drain();
            send_beat(rand_beat());
        end
        drain();
    endtask

    // result side: check every beat against the oldest expectation
    always @(posedge aclk) begin
        prop_out_t want;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time, expected_q.size());
            $display("CHECKS FAILED");
            $finish;
        end
        case (idle_mode)
            IDLE_SNK:  m_tready <= ($urandom_range(99) >= 88);
            IDLE_BOTH: m_tready <= ($urandom_range(99) >= 27);
            default:   m_tready <= 1'b1;
        endcase
        if (aresetn && m_tvalid && m_tready) begin
            n_results++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat thrust=%h torque=%h",
                         $time, m_tdata[47:0], m_tdata[95:48]);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[47:0] !== want.thrust) begin
                    errors++;
                    $display("%0t: thrust mismatch expected %h actual %h",
                             $time, want.thrust, m_tdata[47:0]);
                end
                if (m_tdata[95:48] !== want.torque) begin
                    errors++;
                    $display("%0t: torque mismatch expected %h actual %h",
                             $time, want.torque, m_tdata[95:48]);
                end
            end
        end
    end

    typedef struct {
        prop_beat_t b;
        bit         known;
        prop_out_t  r;
    } dir_row_t;

    dir_row_t dir_rows[$];

    function automatic dir_row_t row(input action_t a, input logic [17:0] rho,
                                     input logic [31:0] vel, input logic [31:0] rot,
                                     input logic [16:0] pcmd, input logic feather,
                                     input logic [31:0] factor, input bit known);
        dir_row_t d;
        d.b = '{a, rho, vel, rot, pcmd, feather, factor};
        d.known = known;
        d.r = '{default: '0};   // zero density gives zero thrust and torque
        return d;
    endfunction

    initial begin
        logic [31:0] set1[8], set2[8], set3[8], set4[8], set5[8];
        radius_q = 64'd65536; base_j0 = 64'd65536; f0_scale = 64'd65536;
        tc_limit = 64'd65536; limit_on = 1'b0; manual_on = 1'b0;
        fine_q = 64'd0; coarse_q = 64'hFFFF_FFFF; j0_now = 64'd65536;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part, reset settings
        dir_rows.push_back(row(ACT_COMPUTE, 0, 0, 0, 0, 0, 0, 1));
        dir_rows.push_back(row(ACT_COMPUTE, 0, 32'h7FFF_FFFF, 32'h8000_0000, 17'h1FFFF, 1,
                               32'hFFFF_FFFF, 1));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h3FFFF, 32'd10 << 16, 32'd10 << 16, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h139C0, 32'd30 << 16, 32'd100 << 16, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h10000, 32'h8000_0000, 32'd50 << 16, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h10000, 32'd5 << 16, 32'h8000_0000, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h10000, 32'd5 << 16, 32'd0, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h10000, 32'd5 << 16, 32'd30, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h3FFFF, 32'h7FFF_FFFF, 32'd1, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h139C0, 32'd40 << 16, 32'd100 << 16, 0, 1, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h139C0, 32'd110 << 16, 32'd100 << 16, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h139C0, 32'd200 << 16, 32'd10 << 16, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h139C0, 32'd60 << 16, 32'd10 << 16, 0, 1, 0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h3FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                               17'h1FFFF, 0, 0, 0));
        dir_rows.push_back(row(ACT_PITCH, 0, 0, 0, 0, 0, 32'h0001_0000, 0));
        dir_rows.push_back(row(ACT_PITCH, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h139C0, 32'd50 << 16, 32'd20 << 16, 0, 0, 0, 0));
        dir_rows.push_back(row(ACT_PITCH, 0, 0, 0, 0, 0, 32'h0, 0));
        dir_rows.push_back(row(ACT_COMPUTE, 18'h139C0, 32'd50 << 16, 32'd20 << 16, 0, 0, 0, 0));
        idle_mode = IDLE_NONE;
        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].b);
            if (dir_rows[i].known && dir_rows[i].b.act == ACT_COMPUTE)
                expected_q[expected_q.size() - 1] = dir_rows[i].r;
        end
        drain();

        // radius, base, f0, tc limit, limit on, manual, fine, coarse
        set1 = '{32'h18000, 32'h10000, 32'h0CCCC, 32'h04CCC, 1, 0, 32'h8000, 32'h20000};
        set2 = '{32'h20000, 32'h14000, 32'h10000, 32'h10000, 0, 1, 32'h0, 32'hFFFF_FFFF};
        set3 = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1, 0,
                 32'hFFFF_FFFF, 32'h0};
        set4 = '{32'h0, 32'h1, 32'h0, 32'hFFFF_FFFF, 0, 0, 32'h0, 32'hFFFF_FFFF};
        set5 = '{32'h0C000, 32'h8000, 32'h30000, 32'hFFFF_FFFF, 1, 1, 32'h4000, 32'h40000};

        write_settings(set1); run_random(IDLE_NONE, N_RANDOM / 5, 0);
        write_settings(set2); run_random(IDLE_SRC,  N_RANDOM / 5, 1);
        write_settings(set3); run_random(IDLE_SNK,  N_RANDOM / 5, 0);
        write_settings(set4); run_random(IDLE_BOTH, N_RANDOM / 5, 0);
        write_settings(set5); run_random(IDLE_BOTH, N_RANDOM / 5, 0);

        $display("Covered %0d beats (%0d pitch), %0d results checked over six settings,",
                 n_beats, n_pitch, n_results);
        $display("with sender gaps, receiver stalls and a full drain mid-phase.");
        if (errors == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", errors, expected_q.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
